[rtl/core/ufms_pkg.sv]
// shared types and constants of the disjoint-set engine
`timescale 1ns / 1ps
`default_nettype none
package ufms_pkg;

   localparam int UFMS_MAX_ELEMENTS = 1024;
   localparam int ELEM_W = 11;
   localparam int COUNT_W = 11;
   localparam int SUM_W = 20;
   localparam logic [ELEM_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      OP_UNION = 2'd0,
      OP_MOVE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SEL_CUR,
      SEL_WALK,
      SEL_FIRST,
      SEL_SECOND,
      SEL_RA,
      SEL_RB
   } addr_sel_type;

   typedef struct packed {
      logic         latch;
      logic         clr_init;
      logic         clr_run;
      addr_sel_type rd_sel;
      logic         save_ra;
      logic         save_rb;
      logic         cap_a;
      logic         cap_b;
      logic         wr_a;
      logic         wr_b;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   a_ok;
      logic   b_ok;
      logic   root_hit;
      logic   same_root;
      logic   clr_done;
      logic   rsp_busy;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/ufms_ram.sv]
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ufms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

[rtl/core/ufms_ctrl.sv]
// controller state machine of the disjoint-set engine
`timescale 1ns / 1ps
`default_nettype none
module ufms_ctrl
   import ufms_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       csr_write_enable,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DEC,
      S_FA,
      S_FB,
      S_RDB,
      S_CAPB,
      S_WRA,
      S_WRB,
      S_QCAP
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE) || csr_write_enable;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = SEL_CUR;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_run = 1'b1;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !csr_write_enable) begin
               cmd.latch = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (status.op == OP_CLEAR) begin
               cmd.clr_init = 1'b1;
               state_in = S_CLEAR;
            end else if (!status.a_ok) begin
               state_in = S_IDLE;
            end else if (status.op != OP_QUERY && !status.b_ok) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_sel = SEL_FIRST;
               state_in = S_FA;
            end
         end
         S_FA: begin
            if (status.root_hit) begin
               cmd.save_ra = 1'b1;
               if (status.op == OP_QUERY) begin
                  cmd.rd_sel = SEL_CUR;
                  state_in = S_QCAP;
               end else begin
                  cmd.rd_sel = SEL_SECOND;
                  state_in = S_FB;
               end
            end else begin
               cmd.rd_sel = SEL_WALK;
            end
         end
         S_FB: begin
            if (status.root_hit) begin
               cmd.save_rb = 1'b1;
               if (status.same_root) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_sel = SEL_RA;
                  state_in = S_RDB;
               end
            end else begin
               cmd.rd_sel = SEL_WALK;
            end
         end
         S_RDB: begin
            cmd.rd_sel = SEL_RB;
            cmd.cap_a = 1'b1;
            state_in = S_CAPB;
         end
         S_CAPB: begin
            cmd.cap_b = 1'b1;
            state_in = S_WRA;
         end
         S_WRA: begin
            cmd.wr_a = 1'b1;
            state_in = (status.op == OP_MOVE) ? S_WRB : S_IDLE;
         end
         S_WRB: begin
            cmd.wr_b = 1'b1;
            state_in = S_IDLE;
         end
         S_QCAP: begin
            cmd.rd_sel = SEL_CUR;
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         cmd.clr_init = 1'b1;
         cmd.latch = 1'b0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !status.rsp_busy)
      else $error("response loaded over a pending beat");
   a_cap_order: assert property (@(posedge clock) disable iff (reset)
      cmd.cap_a && !csr_write_enable |=> cmd.cap_b || csr_write_enable)
      else $error("second capture did not follow the first");
   a_wrb_after_wra: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_b |-> $past(cmd.wr_a))
      else $error("second write without first write");
   a_clear_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_run |-> req_stall)
      else $error("item accepted during clearing pass");

endmodule
`default_nettype wire

[rtl/core/ufms_datapath.sv]
// datapath: tables, walk registers, arithmetic and response register
`timescale 1ns / 1ps
`default_nettype none
module ufms_datapath
   import ufms_pkg::*;
#(
   parameter int MAX_ELEMENTS = UFMS_MAX_ELEMENTS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [1:0]          req_op,
   input  wire logic [ELEM_W-1:0]   req_first_element,
   input  wire logic [ELEM_W-1:0]   req_second_element,
   input  wire logic                csr_write_enable,
   input  wire logic [ELEM_W-1:0]   csr_write_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [COUNT_W-1:0]  rsp_member_count,
   output logic      [SUM_W-1:0]    rsp_element_sum
);

   localparam int DEPTH = 2 * MAX_ELEMENTS + 2;
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] MAX_A = AW'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

   op_type            op_ff;
   logic [ELEM_W-1:0] a_ff, b_ff, cnt_ff;
   logic [AW-1:0]     cur_ff, ra_ff, rb_ff, clr_ff, clr_in;
   logic [SUM_W-1:0]  sa_ff, sb_ff, rsp_sum_ff;
   logic [COUNT_W-1:0] ca_ff, cb_ff, rsp_count_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]      raddr, prd, p_waddr, p_wdata, sc_waddr;
   logic [SUM_W-1:0]   srd, s_wdata;
   logic [COUNT_W-1:0] crd, c_wdata;
   logic               p_we, sc_we;

   function automatic logic elem_ok(input logic [ELEM_W-1:0] e, input logic [ELEM_W-1:0] n);
      return (e != '0) && (32'(e) <= 32'(MAX_ELEMENTS)) && ((e <= n) || (e == 11'd1));
   endfunction

   always_comb begin
      case (cmd.rd_sel)
         SEL_WALK:   raddr = prd;
         SEL_FIRST:  raddr = AW'(a_ff);
         SEL_SECOND: raddr = AW'(b_ff);
         SEL_RA:     raddr = ra_ff;
         SEL_RB:     raddr = rb_ff;
         default:    raddr = cur_ff;
      endcase
   end

   always_comb begin
      p_we = 1'b0;
      sc_we = 1'b0;
      p_waddr = clr_ff;
      sc_waddr = clr_ff;
      p_wdata = (clr_ff <= MAX_A) ? clr_ff + MAX_A : clr_ff;
      s_wdata = (clr_ff <= MAX_A) ? SUM_W'(clr_ff)
              : (clr_ff < LAST_A) ? SUM_W'(clr_ff - MAX_A) : '0;
      c_wdata = COUNT_W'(1);
      if (cmd.clr_run) begin
         p_we = 1'b1;
         sc_we = 1'b1;
      end else if (cmd.wr_a) begin
         p_we = 1'b1;
         sc_we = 1'b1;
         p_wdata = rb_ff;
         if (op_ff == OP_MOVE) begin
            p_waddr = AW'(a_ff);
            sc_waddr = ra_ff;
            s_wdata = sa_ff - SUM_W'(a_ff);
            c_wdata = ca_ff - COUNT_W'(1);
         end else begin
            p_waddr = ra_ff;
            sc_waddr = rb_ff;
            s_wdata = sa_ff + sb_ff;
            c_wdata = ca_ff + cb_ff;
         end
      end else if (cmd.wr_b) begin
         sc_we = 1'b1;
         sc_waddr = rb_ff;
         s_wdata = sb_ff + SUM_W'(a_ff);
         c_wdata = cb_ff + COUNT_W'(1);
      end
   end

   ufms_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(raddr), .rdata(prd)
   );

   ufms_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(s_wdata),
      .raddr(raddr), .rdata(srd)
   );

   ufms_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(c_wdata),
      .raddr(raddr), .rdata(crd)
   );

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clr_init) begin
         clr_in = '0;
      end else if (cmd.clr_run && clr_ff != LAST_A) begin
         clr_in = clr_ff + AW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         cnt_ff <= ELEMENT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         op_ff <= OP_QUERY;
      end else begin
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cnt_ff <= csr_write_data;
         end
         if (cmd.latch) begin
            op_ff <= op_type'(req_op);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= raddr;
      if (cmd.latch) begin
         a_ff <= req_first_element;
         b_ff <= req_second_element;
      end
      if (cmd.save_ra) begin
         ra_ff <= cur_ff;
      end
      if (cmd.save_rb) begin
         rb_ff <= cur_ff;
      end
      if (cmd.cap_a) begin
         sa_ff <= srd;
         ca_ff <= crd;
      end
      if (cmd.cap_b) begin
         sb_ff <= srd;
         cb_ff <= crd;
      end
      if (cmd.rsp_load) begin
         rsp_sum_ff <= srd;
         rsp_count_ff <= crd;
      end
   end

   assign status.op = op_ff;
   assign status.a_ok = elem_ok(a_ff, cnt_ff);
   assign status.b_ok = elem_ok(b_ff, cnt_ff);
   assign status.root_hit = (prd == cur_ff);
   assign status.same_root = (cur_ff == ra_ff);
   assign status.clr_done = (clr_ff == LAST_A);
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_member_count = rsp_count_ff;
   assign rsp_element_sum = rsp_sum_ff;

endmodule
`default_nettype wire

[rtl/core/union_find_with_move_sum_count_unit.sv]
// top level of the disjoint-set engine with move, count and sum
// query: walks to the first element's root, then loads the result; out-of-range items end at decode
// busy: union and move walk both roots, then update the totals; a same-set item stops after the walks
// throughput: one item at a time, the next taken in the idle cycle after; query waits on a stalled beat
// clear item and element_count write: clearing pass over all 2*MAX_ELEMENTS+2 entries, no items taken
// reset: synchronous, starts the same clearing pass; element_count resets to 1024
`timescale 1ns / 1ps
`default_nettype none
module union_find_with_move_sum_count_unit
   import ufms_pkg::*;
#(
   parameter int MAX_ELEMENTS = UFMS_MAX_ELEMENTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [ELEM_W-1:0]  req_first_element,
   input  wire logic [ELEM_W-1:0]  req_second_element,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [COUNT_W-1:0] rsp_member_count,
   output logic      [SUM_W-1:0]   rsp_element_sum,
   input  wire logic               csr_write_enable,
   input  wire logic [ELEM_W-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   ufms_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .csr_write_enable(csr_write_enable),
      .status(status),
      .cmd(cmd)
   );

   ufms_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_op(req_op),
      .req_first_element(req_first_element),
      .req_second_element(req_second_element),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_member_count(rsp_member_count),
      .rsp_element_sum(rsp_element_sum)
   );

endmodule
`default_nettype wire

[bench/union_find_with_move_sum_count_unit_tb.sv]
// testbench for the disjoint-set engine: directed, register and random tests against a predictor
`timescale 1ns / 1ps
`default_nettype none
module union_find_with_move_sum_count_unit_tb;
   import ufms_pkg::*;

   localparam int MAX_N = 1024;
   localparam int DEPTH = 2 * MAX_N + 2;
   localparam int IDLE_WAIT = 6000;
   localparam int WATCHDOG_LIMIT = 60000;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
   } set_total_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [ELEM_W-1:0]  req_first_element;
   logic [ELEM_W-1:0]  req_second_element;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COUNT_W-1:0] rsp_member_count;
   logic [SUM_W-1:0]   rsp_element_sum;
   logic               csr_write_enable;
   logic [ELEM_W-1:0]  csr_write_data;

   int unsigned link_tbl [DEPTH];
   int unsigned sum_tbl [DEPTH];
   int unsigned size_tbl [DEPTH];
   int unsigned elem_limit;
   set_total_type set_totals_q [$];
   int          mismatches;
   int          idle_cycles;
   int          stall_phase;
   int          stall_mode;
   int          burst_left;

   union_find_with_move_sum_count_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_first_element(req_first_element),
      .req_second_element(req_second_element),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_member_count(rsp_member_count),
      .rsp_element_sum(rsp_element_sum),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void restore_singletons();
      for (int i = 0; i < DEPTH; i++) begin
         link_tbl[i] = i;
         sum_tbl[i] = 0;
         size_tbl[i] = 1;
      end
      for (int i = 0; i <= MAX_N; i++) begin
         link_tbl[i] = i + MAX_N;
         link_tbl[i + MAX_N] = i + MAX_N;
         sum_tbl[i] = i;
         sum_tbl[i + MAX_N] = i;
      end
   endfunction

   function automatic int unsigned root_of(int unsigned node);
      int unsigned r;
      int steps;
      r = node;
      steps = 0;
      while (link_tbl[r] != r && steps < DEPTH) begin
         r = link_tbl[r];
         steps++;
      end
      return r;
   endfunction

   function automatic void apply_set_op(op_type op, int unsigned a, int unsigned b);
      int unsigned ra;
      int unsigned rb;
      set_total_type t;
      bit a_ok;
      bit b_ok;
      a_ok = a >= 1 && a <= elem_limit;
      b_ok = b >= 1 && b <= elem_limit;
      if (op == OP_CLEAR) begin
         restore_singletons();
         return;
      end
      if (!a_ok) return;
      if (op == OP_QUERY) begin
         ra = root_of(a);
         t.count = size_tbl[ra][COUNT_W-1:0];
         t.sum = sum_tbl[ra][SUM_W-1:0];
         set_totals_q.push_back(t);
         return;
      end
      if (!b_ok) return;
      ra = root_of(a);
      rb = root_of(b);
      if (ra == rb) return;
      if (op == OP_UNION) begin
         link_tbl[ra] = rb;
         sum_tbl[rb] += sum_tbl[ra];
         size_tbl[rb] += size_tbl[ra];
      end else begin
         sum_tbl[ra] -= a;
         size_tbl[ra] -= 1;
         sum_tbl[rb] += a;
         size_tbl[rb] += 1;
         link_tbl[a] = rb;
      end
   endfunction

   // response check, receiver stall pattern and watchdog
   always @(posedge clock) begin
      set_total_type t;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (set_totals_q.size() == 0) begin
               $display("%0t: beat expected none actual count=%0d sum=%0d", $time,
                        rsp_member_count, rsp_element_sum);
               mismatches++;
            end else begin
               t = set_totals_q.pop_front();
               if (rsp_member_count !== t.count) begin
                  $display("%0t: member_count expected %0d actual %0d", $time,
                           t.count, rsp_member_count);
                  mismatches++;
               end
               if (rsp_element_sum !== t.sum) begin
                  $display("%0t: element_sum expected %0d actual %0d", $time,
                           t.sum, rsp_element_sum);
                  mismatches++;
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_write_enable)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= (stall_phase % 16) < 11;
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_item(op_type op, int unsigned a, int unsigned b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_first_element <= a[ELEM_W-1:0];
      req_second_element <= b[ELEM_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_set_op(op, a[ELEM_W-1:0], b[ELEM_W-1:0]);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (set_totals_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_element_count(int unsigned value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value[ELEM_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      elem_limit = value == 0 ? 1 : (value > MAX_N ? MAX_N : value);
      restore_singletons();
   endtask

   task automatic test_directed();
      send_item(OP_QUERY, 1, 0);
      send_item(OP_QUERY, 1024, 2047);
      send_item(OP_QUERY, 0, 0);
      send_item(OP_QUERY, 2047, 0);
      send_item(OP_UNION, 1, 2);
      send_item(OP_QUERY, 1, 0);
      send_item(OP_UNION, 1024, 1);
      send_item(OP_QUERY, 2, 0);
      send_item(OP_MOVE, 2, 3);
      send_item(OP_QUERY, 2, 0);
      send_item(OP_QUERY, 1024, 0);
      send_item(OP_UNION, 2, 3);
      send_item(OP_MOVE, 3, 2);
      send_item(OP_UNION, 1, 0);
      send_item(OP_MOVE, 5, 2047);
      send_item(OP_UNION, 1025, 4);
      send_item(OP_QUERY, 3, 0);
      send_item(OP_CLEAR, 2047, 2047);
      send_item(OP_QUERY, 3, 0);
      send_item(OP_QUERY, 1024, 0);
   endtask

   task automatic random_items(int num);
      op_type op;
      int unsigned a;
      int unsigned b;
      int sel;
      for (int i = 0; i < num; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) op = OP_UNION;
         else if (sel < 60) op = OP_MOVE;
         else if (sel < 98) op = OP_QUERY;
         else op = OP_CLEAR;
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 2047);
            b = $urandom_range(0, 2047);
         end else begin
            a = $urandom_range(1, elem_limit);
            b = $urandom_range(1, elem_limit);
         end
         send_item(op, a, b);
      end
   endtask

   task automatic test_element_count();
      write_element_count(0);
      random_items(15);
      write_element_count(1);
      random_items(15);
      write_element_count(2047);
      random_items(30);
      write_element_count(2);
      random_items(25);
   endtask

   task automatic test_random();
      write_element_count(12);
      random_items(250);
      wait_idle();
      random_items(50);
      write_element_count(60);
      random_items(250);
      write_element_count(1024);
      random_items(200);
      write_element_count(1500);
      random_items(100);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_UNION;
      req_first_element = '0;
      req_second_element = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatches = 0;
      idle_cycles = 0;
      stall_phase = 0;
      stall_mode = 0;
      burst_left = 0;
      elem_limit = MAX_N;
      restore_singletons();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_element_count();
      test_random();
      wait_idle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

[union_find_with_move_sum_count_unit.f]
rtl/core/ufms_pkg.sv
rtl/core/ufms_ram.sv
rtl/core/ufms_ctrl.sv
rtl/core/ufms_datapath.sv
rtl/core/union_find_with_move_sum_count_unit.sv
bench/union_find_with_move_sum_count_unit_tb.sv
